### rtl/bslut_pkg.sv
package bslut_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // input command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // configuration register indexes
    localparam logic CFG_SKIN_PRIOR       = 1'b0;
    localparam logic CFG_LIKELIHOOD_SCALE = 1'b1;

    // register formats
    localparam int PRIOR_W    = 17;
    localparam int SCALE_W    = 25;
    localparam int SCALE_FRAC = 24;
    localparam int KL_W       = 16;
    localparam int KH_W       = SCALE_W - KL_W;
    localparam int CFG_DATA_W = 25;

    localparam logic [PRIOR_W-1:0] PRIOR_ONE     = 17'd65536;
    localparam logic [SCALE_W-1:0] SCALE_ONE     = 25'd16777216;
    localparam logic [PRIOR_W-1:0] PRIOR_RESET   = 17'd32768;
    localparam logic [SCALE_W-1:0] SCALE_RESET   = 25'd33873;

    // quotient is one byte, found one bit a cycle
    localparam int LEVEL_W   = 8;
    localparam int DIV_STEPS = 8;

    // multiply sequencer steps
    localparam logic [3:0] MS_PRIOR_SKIN = 4'd0;
    localparam logic [3:0] MS_REST_NON   = 4'd1;
    localparam logic [3:0] MS_TAKE_X     = 4'd2;
    localparam logic [3:0] MS_XL_KL      = 4'd3;
    localparam logic [3:0] MS_XL_KH      = 4'd4;
    localparam logic [3:0] MS_XH_KL      = 4'd5;
    localparam logic [3:0] MS_XH_KH      = 4'd6;
    localparam logic [3:0] MS_LAST_ADD   = 4'd7;
    localparam logic [3:0] MS_DENOM      = 4'd8;

    // rgb skin rule thresholds on 8-bit bin corners
    localparam logic [8:0] RULE_RED_MIN   = 9'd95;
    localparam logic [8:0] RULE_GREEN_MIN = 9'd40;
    localparam logic [8:0] RULE_BLUE_MIN  = 9'd20;
    localparam logic [8:0] RULE_MARGIN    = 9'd15;

endpackage

### rtl/bslut_ram.sv
module bslut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read data holds while the port is idle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bayesian_skin_color_lut.sv
// pixel lookup: ram read, then output register; one pixel per cycle (one ram read)
//   unless the output stalls. bin load: 9 multiply steps on one shared multiplier,
//   a one-bit-per-cycle divider and a write-back state, one load at a time
// reset: asynchronous, active low; restores the register defaults, then a clearing
//   pass writes zero to all 2^(3*BIN_BITS) table entries, during which no input
//   transaction is taken
module bayesian_skin_color_lut
    import bslut_pkg::*;
#(
    parameter int BIN_BITS   = 5,
    parameter int COUNT_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [BIN_BITS-1:0]   bin_blue,
    input  logic [BIN_BITS-1:0]   bin_green,
    input  logic [BIN_BITS-1:0]   bin_red,
    input  logic [COUNT_BITS-1:0] skin_count,
    input  logic [COUNT_BITS-1:0] nonskin_count,
    input  logic [7:0]            pixel_blue,
    input  logic [7:0]            pixel_green,
    input  logic [7:0]            pixel_red,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LEVEL_W-1:0]    skin_level
);

    // table geometry
    localparam int ADDR_W = 3 * BIN_BITS;
    localparam int DEPTH  = 1 << ADDR_W;

    // datapath widths
    localparam int CB     = COUNT_BITS;
    localparam int AW     = CB + PRIOR_W;          // prior times skin count
    localparam int XW     = CB + PRIOR_W;          // (1 - prior) times non-skin count
    localparam int MA     = (CB > PRIOR_W) ? CB : PRIOR_W;
    localparam int PROD_W = MA + PRIOR_W;
    localparam int ACC_W  = XW + SCALE_W;
    localparam int DW     = XW + 2;                // denominator, possibly doubled
    localparam int RW     = DW + DIV_STEPS - 1;    // divider remainder and shifted divisor

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [PRIOR_W-1:0] skin_prior_reg;
    logic [SCALE_W-1:0] likelihood_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skin_prior_reg       <= PRIOR_RESET;
            likelihood_scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SKIN_PRIOR:       skin_prior_reg       <= cfg_data[PRIOR_W-1:0];
                CFG_LIKELIHOOD_SCALE: likelihood_scale_reg <= cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    // prior and scale saturate at 1.0
    logic [PRIOR_W-1:0] prior_sat;
    logic [PRIOR_W-1:0] prior_rest;
    logic [SCALE_W-1:0] scale_sat;

    assign prior_sat  = (skin_prior_reg > PRIOR_ONE) ? PRIOR_ONE : skin_prior_reg;
    assign prior_rest = PRIOR_ONE - prior_sat;
    assign scale_sat  = (likelihood_scale_reg > SCALE_ONE) ? SCALE_ONE : likelihood_scale_reg;

    // ------------------------------------------------------------------
    // input decode: table index and skin rule on the bin corner
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] load_idx;
    logic [ADDR_W-1:0] pixel_idx;
    logic [8:0]        corner_b;
    logic [8:0]        corner_g;
    logic [8:0]        corner_r;
    logic [8:0]        corner_lo;
    logic              rule_pass;

    assign load_idx  = {bin_blue, bin_green, bin_red};
    assign pixel_idx = {pixel_blue[7 -: BIN_BITS], pixel_green[7 -: BIN_BITS],
                        pixel_red[7 -: BIN_BITS]};

    assign corner_b  = 9'(bin_blue)  << (8 - BIN_BITS);
    assign corner_g  = 9'(bin_green) << (8 - BIN_BITS);
    assign corner_r  = 9'(bin_red)   << (8 - BIN_BITS);
    assign corner_lo = (corner_b < corner_g) ? corner_b : corner_g;

    assign rule_pass = (corner_r > RULE_RED_MIN) && (corner_g > RULE_GREEN_MIN)
                    && (corner_b > RULE_BLUE_MIN) && (corner_r > corner_b)
                    && (corner_r > corner_g + RULE_MARGIN)
                    && (corner_r > corner_lo + RULE_MARGIN);

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [3:0]        step_reg;
    logic [2:0]        div_cnt_reg;
    logic              out_valid_reg;
    logic [LEVEL_W-1:0] skin_level_reg;

    logic              out_free;
    logic              in_take;
    logic              out_load;
    logic [LEVEL_W-1:0] out_data;

    // table ram port
    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [LEVEL_W-1:0] ram_wdata;
    logic [LEVEL_W-1:0] ram_rdata;

    // load datapath
    logic [ADDR_W-1:0]  idx_reg;
    logic               full_reg;
    logic [CB-1:0]      s_reg;
    logic [CB-1:0]      n_reg;
    logic [AW-1:0]      a_reg;
    logic [XW-1:0]      x_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [RW-1:0]      rem_reg;
    logic [RW-1:0]      dsh_reg;
    logic               dzero_reg;
    logic [LEVEL_W-1:0] q_reg;
    logic [LEVEL_W-1:0] lvl_reg;

    // output register frees up when empty or being taken
    assign out_free = !out_valid_reg || !out_stall;
    assign in_take  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE, ST_READ:
            begin
                priority if (state_reg == ST_READ && !out_free)
                begin
                    state_next = ST_READ;
                end
                else if (in_take)
                begin
                    state_next = (command == CMD_PIXEL) ? ST_READ : ST_MUL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                if (step_reg == MS_DENOM)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 3'd0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the controller: handshake, ram port, output load
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = !((state_reg == ST_IDLE) || (state_reg == ST_READ && out_free));
        out_load  = out_free && (state_reg == ST_READ || state_reg == ST_DONE);
        out_data  = (state_reg == ST_READ) ? ram_rdata : lvl_reg;

        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = pixel_idx;
        ram_wdata = '0;
        priority if (state_reg == ST_CLEAR)
        begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = clr_cnt_reg;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            // write back the new level as it goes out
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = idx_reg;
            ram_wdata = lvl_reg;
        end
        else if (in_valid && !in_stall && command == CMD_PIXEL)
        begin
            ram_en = 1'b1;
        end
    end

    bslut_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            step_reg      <= MS_PRIOR_SKIN;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            if (in_take)
            begin
                step_reg <= MS_PRIOR_SKIN;
            end
            else if (state_reg == ST_MUL)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (state_reg == ST_MUL && step_reg == MS_DENOM)
            begin
                div_cnt_reg <= 3'(DIV_STEPS - 1);
            end
            else if (state_reg == ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // shared multiplier: operand select by sequencer step
    // x*k is built from four partial products, k split into high and low parts
    // ------------------------------------------------------------------
    logic [MA-1:0]      mul_a;
    logic [PRIOR_W-1:0] mul_b;
    logic [CB-1:0]      x_lo;
    logic [PRIOR_W-1:0] x_hi;
    logic [KL_W-1:0]    k_lo;
    logic [KH_W-1:0]    k_hi;

    assign x_lo = x_reg[CB-1:0];
    assign x_hi = x_reg[XW-1:CB];
    assign k_lo = scale_sat[KL_W-1:0];
    assign k_hi = scale_sat[SCALE_W-1:KL_W];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            MS_PRIOR_SKIN:
            begin
                mul_a = MA'(s_reg);
                mul_b = prior_sat;
            end
            MS_REST_NON:
            begin
                mul_a = MA'(n_reg);
                mul_b = prior_rest;
            end
            MS_XL_KL:
            begin
                mul_a = MA'(x_lo);
                mul_b = PRIOR_W'(k_lo);
            end
            MS_XL_KH:
            begin
                mul_a = MA'(x_lo);
                mul_b = PRIOR_W'(k_hi);
            end
            MS_XH_KL:
            begin
                mul_a = MA'(x_hi);
                mul_b = PRIOR_W'(k_lo);
            end
            MS_XH_KH:
            begin
                mul_a = MA'(x_hi);
                mul_b = PRIOR_W'(k_hi);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // denominator from a and the scaled non-skin term, doubled when the rule fails
    logic [DW-1:0] denom_sum;
    logic [DW-1:0] denom;
    logic          div_ge;
    logic [RW-1:0] div_diff;

    assign denom_sum = DW'(a_reg) + DW'(acc_reg[ACC_W-1:SCALE_FRAC]);
    assign denom     = full_reg ? denom_sum : (denom_sum << 1);
    assign div_ge    = (rem_reg >= dsh_reg);
    assign div_diff  = rem_reg - dsh_reg;

    // ------------------------------------------------------------------
    // load datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take && command == CMD_LOAD)
        begin
            idx_reg  <= load_idx;
            full_reg <= rule_pass;
            s_reg    <= skin_count;
            n_reg    <= nonskin_count;
        end

        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(mul_a * mul_b);
            unique case (step_reg)
                MS_REST_NON: a_reg   <= AW'(prod_reg);
                MS_TAKE_X:   x_reg   <= XW'(prod_reg);
                MS_XL_KH:    acc_reg <= ACC_W'(prod_reg);
                MS_XH_KL:    acc_reg <= acc_reg + (ACC_W'(prod_reg) << KL_W);
                MS_XH_KH:    acc_reg <= acc_reg + (ACC_W'(prod_reg) << CB);
                MS_LAST_ADD: acc_reg <= acc_reg + (ACC_W'(prod_reg) << (CB + KL_W));
                MS_DENOM:
                begin
                    // numerator 255*a, divisor aligned to the top quotient bit
                    rem_reg   <= RW'({a_reg, 8'd0}) - RW'(a_reg);
                    dsh_reg   <= RW'(denom) << (DIV_STEPS - 1);
                    dzero_reg <= (denom == '0);
                    q_reg     <= '0;
                end
                default:
                begin
                end
            endcase
        end

        // restoring division, one quotient bit a cycle
        if (state_reg == ST_DIV)
        begin
            if (div_ge)
            begin
                rem_reg <= div_diff;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[LEVEL_W-2:0], div_ge};
            if (div_cnt_reg == 3'd0)
            begin
                // a zero denominator means a is zero too, so the level is zero
                lvl_reg <= dzero_reg ? '0 : {q_reg[LEVEL_W-2:0], div_ge};
            end
        end

        if (out_load)
        begin
            skin_level_reg <= out_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign skin_level = skin_level_reg;

`ifndef SYNTH
    // clearing pass only ends after the last table entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR && $past(state_reg == ST_CLEAR))
            |-> $past(clr_cnt_reg) == ADDR_W'(DEPTH - 1))
        else $error("clearing pass ended early");

    // a pixel result in the read state comes from a read issued the cycle before, or is held by an output stall
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ)
            |-> ($past(ram_en && !ram_we) || $past(state_reg == ST_READ && !out_free)))
        else $error("read state without a table read");

    // no transaction is taken while a load is being computed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DIV || state_reg == ST_DONE) |-> in_stall)
        else $error("input taken during a bin load");

    // the divider always runs into the write-back state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |=> (state_reg == ST_DIV || state_reg == ST_DONE))
        else $error("divider left early");
`endif

endmodule
